### design/ev1527_pulse_width_encoder_core_macros.svh
// Assertion macros shared by the pulse-width encoder RTL.
`ifndef EV1527_PULSE_WIDTH_ENCODER_CORE_MACROS_SVH
`define EV1527_PULSE_WIDTH_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EV1527_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EV1527_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ev1527_pkg.sv
// Types and constants shared by the pulse-width encoder modules.
package ev1527_pkg;

  localparam int CODE_W = 24;
  localparam int UNIT_W = 8;
  localparam int TICK_W = 13;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Phase lengths in pulse units.
  localparam int SYNC_LO_UNITS  = 31;
  localparam int BIT_LONG_UNITS = 3;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 8'd4;

  // Register index, taken from the word address.
  localparam logic [ADDR_W-3:0] REG_UNIT_TICKS = 1'b0;

  // Action codes of an input item.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SYNC_HI = 3'd1,
    PH_SYNC_LO = 3'd2,
    PH_BIT_HI  = 3'd3,
    PH_BIT_LO  = 3'd4
  } phase_t;

  typedef struct packed {
    logic              action;
    logic [CODE_W-1:0] code;
  } in_item_t;

  typedef struct packed {
    logic rf_level;
    logic tx_led;
    logic busy_res;
    logic start_ignored;
  } out_item_t;

endpackage

### design/ev1527_if.sv
// Valid/ready channel interfaces for the encoder's request and result streams.
interface ev1527_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [ev1527_pkg::CODE_W-1:0] code;

  modport source (output valid, action, code, input ready);
  modport sink (input valid, action, code, output ready);
endinterface

interface ev1527_out_if;
  logic valid;
  logic ready;
  logic rf_level;
  logic tx_led;
  logic busy_res;
  logic start_ignored;

  modport source (output valid, rf_level, tx_led, busy_res, start_ignored, input ready);
  modport sink (input valid, rf_level, tx_led, busy_res, start_ignored, output ready);
endinterface

### design/ev1527_cfg.sv
// APB-style register file holding the pulse unit length.
module ev1527_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ev1527_pkg::ADDR_W-1:0]       paddr,
  input  logic [ev1527_pkg::DATA_W-1:0]       pwdata,
  output logic [ev1527_pkg::DATA_W-1:0]       prdata,
  output logic                                pready,
  output logic [ev1527_pkg::UNIT_W-1:0]       unit_ticks
);

  logic [ev1527_pkg::UNIT_W-1:0]   unit_ticks_r;
  logic [ev1527_pkg::ADDR_W-3:0]   reg_idx;
  logic                            wr_en;

  // Word index and write strobe of the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ev1527_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Unit length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= ev1527_pkg::UNIT_TICKS_RESET;
    end else if (wr_en && (reg_idx == ev1527_pkg::REG_UNIT_TICKS)) begin
      unit_ticks_r <= pwdata[ev1527_pkg::UNIT_W-1:0];
    end
  end

  // Read data; unmapped words read as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == ev1527_pkg::REG_UNIT_TICKS) begin
      prdata = {{(ev1527_pkg::DATA_W - ev1527_pkg::UNIT_W){1'b0}}, unit_ticks_r};
    end
  end

  assign unit_ticks = unit_ticks_r;

endmodule

### design/ev1527_fsm.sv
// Frame sequencer: phase state machine, code shifter and tick counter.
`include "ev1527_pulse_width_encoder_core_macros.svh"

module ev1527_fsm #(
  parameter int CODE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  ev1527_pkg::in_item_t          item,
  input  logic [ev1527_pkg::UNIT_W-1:0] unit_ticks,
  output ev1527_pkg::out_item_t         result
);

  localparam int BL_W = $clog2(CODE_BITS + 1);

  ev1527_pkg::phase_t               phase_r, phase_nxt;
  logic [CODE_BITS-1:0]             code_shift_r, code_shift_nxt;
  logic [BL_W-1:0]                  bits_left_r, bits_left_nxt;
  logic [ev1527_pkg::TICK_W-1:0]    tick_count_r, tick_count_nxt;

  logic [ev1527_pkg::UNIT_W-1:0]    unit_len;
  logic [ev1527_pkg::TICK_W-1:0]    len_one, len_three, len_sync, phase_len, tick_inc;
  logic [BL_W-1:0]                  bits_dec;
  logic                             busy, level, cur_bit;

  // Phase lengths from the current unit length; a zero unit counts as one.
  assign unit_len  = (unit_ticks == '0) ? ev1527_pkg::UNIT_W'(1) : unit_ticks;
  assign len_one   = ev1527_pkg::TICK_W'(unit_len);
  assign len_three = len_one * ev1527_pkg::TICK_W'(ev1527_pkg::BIT_LONG_UNITS);
  assign len_sync  = len_one * ev1527_pkg::TICK_W'(ev1527_pkg::SYNC_LO_UNITS);
  assign cur_bit   = code_shift_r[0];
  assign tick_inc  = tick_count_r + ev1527_pkg::TICK_W'(1);
  assign bits_dec  = (bits_left_r != '0) ? bits_left_r - BL_W'(1) : '0;

  // Decode of the current phase: busy flag, pin level and phase length.
  always_comb begin
    busy      = 1'b0;
    level     = 1'b0;
    phase_len = len_one;
    case (phase_r)
      ev1527_pkg::PH_SYNC_HI: begin
        busy  = 1'b1;
        level = 1'b1;
      end
      ev1527_pkg::PH_SYNC_LO: begin
        busy      = 1'b1;
        phase_len = len_sync;
      end
      ev1527_pkg::PH_BIT_HI: begin
        busy      = 1'b1;
        level     = 1'b1;
        phase_len = cur_bit ? len_three : len_one;
      end
      ev1527_pkg::PH_BIT_LO: begin
        busy      = 1'b1;
        phase_len = cur_bit ? len_one : len_three;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Next state and result for the item being processed.
  always_comb begin
    phase_nxt      = phase_r;
    code_shift_nxt = code_shift_r;
    bits_left_nxt  = bits_left_r;
    tick_count_nxt = tick_count_r;
    result         = '0;
    if (item.action == ev1527_pkg::ACT_START) begin
      result.busy_res = 1'b1;
      result.tx_led   = 1'b1;
      if (busy) begin
        result.start_ignored = 1'b1;
        result.rf_level      = level;
      end else begin
        code_shift_nxt  = CODE_BITS'(item.code);
        bits_left_nxt   = BL_W'(CODE_BITS);
        phase_nxt       = ev1527_pkg::PH_SYNC_HI;
        tick_count_nxt  = '0;
        result.rf_level = 1'b1;
      end
    end else if (busy) begin
      result.busy_res = 1'b1;
      result.tx_led   = 1'b1;
      result.rf_level = level;
      tick_count_nxt  = tick_inc;
      if (tick_inc >= phase_len) begin
        tick_count_nxt = '0;
        case (phase_r)
          ev1527_pkg::PH_SYNC_HI: phase_nxt = ev1527_pkg::PH_SYNC_LO;
          ev1527_pkg::PH_SYNC_LO: phase_nxt = ev1527_pkg::PH_BIT_HI;
          ev1527_pkg::PH_BIT_HI:  phase_nxt = ev1527_pkg::PH_BIT_LO;
          ev1527_pkg::PH_BIT_LO: begin
            code_shift_nxt = code_shift_r >> 1;
            bits_left_nxt  = bits_dec;
            phase_nxt      = (bits_dec == '0) ? ev1527_pkg::PH_IDLE : ev1527_pkg::PH_BIT_HI;
          end
          default: phase_nxt = ev1527_pkg::PH_IDLE;
        endcase
      end
    end else begin
      phase_nxt = ev1527_pkg::PH_IDLE;
    end
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ev1527_pkg::PH_IDLE;
      code_shift_r <= '0;
      bits_left_r  <= '0;
      tick_count_r <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      code_shift_r <= code_shift_nxt;
      bits_left_r  <= bits_left_nxt;
      tick_count_r <= tick_count_nxt;
    end
  end

  // A start is only ever flagged as ignored while a frame is running.
  `EV1527_ASSERT_IMP(a_ignored_busy, clk, rst_n, step && result.start_ignored, phase_r != ev1527_pkg::PH_IDLE, "start ignored while idle")
  // The sequencer holds its phase when no item is processed.
  `EV1527_ASSERT_NXT(a_phase_hold, clk, rst_n, !step, $stable(phase_r), "phase moved without an item")
  // A running frame always has at least one data bit left.
  `EV1527_ASSERT_IMP(a_bits_left, clk, rst_n, phase_r != ev1527_pkg::PH_IDLE, bits_left_r != '0, "frame running with no bits left")

endmodule

### design/ev1527_pulse_width_encoder_core.sv
// Pulse-width frame encoder top level: input register, sequencer and result register.
//
// Usage: each transfer on in_chan is one item: action 0 is one time tick,
// action 1 a start request carrying a code word. Every item yields exactly one
// transfer on out_chan with the RF pin level, LED, busy flag and an
// ignored-start flag. A start while idle opens a frame: a sync (high one unit,
// low 31 units) and then CODE_BITS data bits, least significant first.
// A unit lasts unit_ticks ticks, set through the APB-style port at word 0.
// An item passes from the input register through the sequencer into the result
// register, which offers its result. The core takes one item per cycle while out_chan
// takes results; the phase, tick counter and code shifter update between the two.
// Reset (synchronous, rst_n low) empties both registers, returns the sequencer
// to idle and sets unit_ticks to 4. When the receiver stalls, the result
// register holds its item and the input register takes one more item; after
// that in_chan.ready drops until the result is taken.
// Write unit_ticks only while no items are in flight.
`include "ev1527_pulse_width_encoder_core_macros.svh"

module ev1527_pulse_width_encoder_core #(
  parameter int CODE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ev1527_in_if.sink                     in_chan,
  ev1527_out_if.source                  out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ev1527_pkg::ADDR_W-1:0] paddr,
  input  logic [ev1527_pkg::DATA_W-1:0] pwdata,
  output logic [ev1527_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);

  logic                          in_valid_r;
  ev1527_pkg::in_item_t          in_data_r;
  logic                          out_valid_r;
  ev1527_pkg::out_item_t         out_data_r;
  ev1527_pkg::out_item_t         result;
  logic [ev1527_pkg::UNIT_W-1:0] unit_ticks;
  logic                          advance, step, in_ready;

  ev1527_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .unit_ticks (unit_ticks)
  );

  ev1527_fsm #(
    .CODE_BITS (CODE_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (in_data_r),
    .unit_ticks (unit_ticks),
    .result     (result)
  );

  // Pipeline flow control: the result register frees up when empty or taken.
  assign advance       = !out_valid_r || out_chan.ready;
  assign step          = in_valid_r && advance;
  assign in_ready      = !in_valid_r || advance;
  assign in_chan.ready = in_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      in_data_r.action <= in_chan.action;
      in_data_r.code   <= in_chan.code;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.rf_level      = out_data_r.rf_level;
  assign out_chan.tx_led        = out_data_r.tx_led;
  assign out_chan.busy_res      = out_data_r.busy_res;
  assign out_chan.start_ignored = out_data_r.start_ignored;

  // A processed item always lands in the result register.
  `EV1527_ASSERT_NXT(a_step_out, clk, rst_n, step, out_valid_r, "processed item lost")
  // A waiting input item is kept intact until it is processed.
  `EV1527_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid_r && !advance, in_valid_r && $stable(in_data_r), "waiting input item changed")
  // The LED always mirrors the busy flag.
  `EV1527_ASSERT_IMP(a_led_busy, clk, rst_n, out_valid_r, out_data_r.tx_led == out_data_r.busy_res, "LED differs from busy flag")

endmodule
